/* rtl/absc_pkg.sv */
package absc_pkg;

    localparam logic [15:0] OPCODE_BYTE_POS = 16'd21;
    localparam logic [7:0]  OPCODE_REPLY    = 8'd2;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic is_reply;
        logic empty;
        logic has_room;
        logic ip_match;
        logic last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic mark_reply;
        logic rd_first;
        logic rd_next;
        logic append;
        logic set_found;
        logic set_full;
        logic emit;
    } ctrl_t;

endpackage

/* rtl/absc_ram.sv */
module absc_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 128
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/absc_ctrl.sv */
module absc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  absc_pkg::status_t status,
    output absc_pkg::ctrl_t   ctrl
);

    absc_pkg::state_t state_reg;
    absc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= absc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            absc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = absc_pkg::ST_CHECK;
                end
            end
            absc_pkg::ST_CHECK:
            begin
                if (status.is_reply && !status.empty)
                begin
                    state_next = absc_pkg::ST_SEARCH;
                end
                else
                begin
                    state_next = absc_pkg::ST_RESULT;
                end
            end
            absc_pkg::ST_SEARCH:
            begin
                if (status.ip_match || status.last)
                begin
                    state_next = absc_pkg::ST_RESULT;
                end
            end
            absc_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = absc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = absc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            absc_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.capture  = in_valid;
            end
            absc_pkg::ST_CHECK:
            begin
                if (status.is_reply)
                begin
                    ctrl.mark_reply = 1'b1;
                    if (!status.empty)
                    begin
                        ctrl.rd_first = 1'b1;
                    end
                    else if (status.has_room)
                    begin
                        ctrl.append = 1'b1;
                    end
                    else
                    begin
                        ctrl.set_full = 1'b1;
                    end
                end
            end
            absc_pkg::ST_SEARCH:
            begin
                priority if (status.ip_match)
                begin
                    ctrl.set_found = 1'b1;
                end
                else if (status.last)
                begin
                    ctrl.append   = status.has_room;
                    ctrl.set_full = !status.has_room;
                end
                else
                begin
                    ctrl.rd_next = 1'b1;
                end
            end
            absc_pkg::ST_RESULT:
            begin
                ctrl.emit = status.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

/* rtl/arp_binding_spoof_checker.sv */
// ARP binding spoof checker. Each input beat carries one captured ARP frame's
// length, opcode low byte, sender MAC and sender IP; each beat yields exactly
// one result beat. Only replies whose capture covers the opcode byte are
// processed: their sender IP is searched linearly in a table of TABLE_DEPTH
// IP/MAC bindings held in one single-port-read RAM. A hit returns the stored
// MAC and flags a spoof if that MAC differs; a miss appends the binding, or
// sets table_full if there is no room. The block takes one item at a time:
// the search does one table read and one IP compare per cycle, from the first
// binding until a hit or the end of the table. Non-reply frames and replies
// against an empty table go from the check state straight to the result
// state. A stalled output holds the block in its result state until the
// waiting beat leaves.
// A finished result waits in the output register while the next beat is taken.
module arp_binding_spoof_checker #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] captured_len,
    input  logic [7:0]  opcode_low,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        was_reply,
    output logic        spoof_detected,
    output logic [47:0] previous_mac,
    output logic        learned,
    output logic        table_full
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = absc_pkg::IP_W + absc_pkg::MAC_W;

    absc_pkg::status_t status;
    absc_pkg::ctrl_t   ctrl;

    logic                        is_reply_reg;
    logic [absc_pkg::IP_W-1:0]   ip_reg;
    logic [absc_pkg::MAC_W-1:0]  mac_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [ADDR_W-1:0]           idx_reg;

    logic                        res_reply_reg;
    logic                        res_spoof_reg;
    logic [absc_pkg::MAC_W-1:0]  res_prev_reg;
    logic                        res_learned_reg;
    logic                        res_full_reg;

    logic                        out_valid_reg;
    logic                        out_reply_reg;
    logic                        out_spoof_reg;
    logic [absc_pkg::MAC_W-1:0]  out_prev_reg;
    logic                        out_learned_reg;
    logic                        out_full_reg;

    logic [ENTRY_W-1:0]          rd_data;
    logic [ADDR_W-1:0]           rd_addr;
    logic [absc_pkg::IP_W-1:0]   rd_ip;
    logic [absc_pkg::MAC_W-1:0]  rd_mac;

    assign rd_ip  = rd_data[ENTRY_W-1 -: absc_pkg::IP_W];
    assign rd_mac = rd_data[absc_pkg::MAC_W-1:0];

    assign rd_addr = ctrl.rd_first ? '0 : ADDR_W'(idx_reg + 1'b1);

    absc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ctrl.append),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({ip_reg, mac_reg}),
        .rd_en   (ctrl.rd_first | ctrl.rd_next),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        status.is_reply = is_reply_reg;
        status.empty    = (count_reg == '0);
        status.has_room = (count_reg != CNT_W'(TABLE_DEPTH));
        status.ip_match = (rd_ip == ip_reg);
        status.last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        status.out_free = !out_valid_reg || out_ready;
    end

    absc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    // hold the item under test and walk the table index
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            is_reply_reg <= (captured_len > absc_pkg::OPCODE_BYTE_POS)
                            && (opcode_low == absc_pkg::OPCODE_REPLY);
            ip_reg       <= sender_ip;
            mac_reg      <= sender_mac;
        end
        if (ctrl.rd_first)
        begin
            idx_reg <= '0;
        end
        else if (ctrl.rd_next)
        begin
            idx_reg <= ADDR_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            res_reply_reg   <= 1'b0;
            res_spoof_reg   <= 1'b0;
            res_prev_reg    <= '0;
            res_learned_reg <= 1'b0;
            res_full_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.mark_reply)
            begin
                res_reply_reg <= 1'b1;
            end
            if (ctrl.set_found)
            begin
                res_spoof_reg <= (rd_mac != mac_reg);
                res_prev_reg  <= rd_mac;
            end
            if (ctrl.append)
            begin
                res_learned_reg <= 1'b1;
            end
            if (ctrl.set_full)
            begin
                res_full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.append)
        begin
            count_reg <= CNT_W'(count_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_reply_reg   <= res_reply_reg;
            out_spoof_reg   <= res_spoof_reg;
            out_prev_reg    <= res_prev_reg;
            out_learned_reg <= res_learned_reg;
            out_full_reg    <= res_full_reg;
        end
    end

    assign in_ready       = ctrl.in_ready;
    assign out_valid      = out_valid_reg;
    assign was_reply      = out_reply_reg;
    assign spoof_detected = out_spoof_reg;
    assign previous_mac   = out_prev_reg;
    assign learned        = out_learned_reg;
    assign table_full     = out_full_reg;

endmodule
